[rtl/ler_pkg.sv]
`default_nettype none

package ler_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 9;
   localparam int INDEX_W  = 8;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 9;
   localparam int RSP_DATA_W = 32;

   localparam int MAX_LINE = 256;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // characters
   localparam logic [BYTE_W-1:0] CH_EOT   = 8'h04;
   localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCRIPTOR = 1'b1;

   localparam logic [POS_W-1:0] LIMIT_RESET = POS_W'(MAX_LINE);

   typedef enum logic [KIND_W-1:0] {
      KIND_ECHO  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OP_ERROR,
      OP_EOT,
      OP_BS,
      OP_CR,
      OP_CHAR_MORE,
      OP_CHAR_END
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   data;
      logic [INDEX_W-1:0]  index;
      logic [POS_W-1:0]    length;
   } cmd_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   data;
      logic [INDEX_W-1:0]  index;
      logic [POS_W-1:0]    length;
      logic                last;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/line_edit_receiver.sv]
`default_nettype none
// channel   direction  handshake             payload
// req       in         req_tvalid/tready     tdata[7:0] rx_byte
// rsp       out        rsp_tvalid/tready     tdata data_byte,write_index,line_length;
//                                            tuser kind; tlast last
// csr       in         csr_we                csr_index, csr_wdata
//
// a byte is taken whenever the four-entry command queue has room
// the back end emits one result per cycle unless rsp stalls, so a byte yields 1 to 4
// results; the single output register sets that rate
// a backspace at line start is dropped in the front
// reset (synchronous) clears fill position, queue and output; limit 256, descriptor 0
// a stall on rsp fills the queue, then req_tready drops

module line_edit_receiver (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input items
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // rx_byte[7:0]
   // result items
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [ler_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // data_byte[7:0],
                                                              // write_index[15:8],
                                                              // line_length[24:16], zeros
   output logic [ler_pkg::KIND_W-1:0]            rsp_tuser,   // kind[1:0]
   output logic                                  rsp_tlast,   // last result of the item
   // configuration writes
   input  wire logic                             csr_we,
   input  wire logic [ler_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ler_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ler_pkg::*;

   // configuration registers
   logic [POS_W-1:0]  limit_ff, limit_in;
   logic [BYTE_W-1:0] desc_ff, desc_in;

   always_comb begin
      limit_in = limit_ff;
      desc_in  = desc_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_LIMIT: limit_in = csr_wdata;
            CSR_DESCRIPTOR: desc_in  = csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         desc_ff  <= '0;
      end else begin
         limit_ff <= limit_in;
         desc_ff  <= desc_in;
      end
   end

   // front: classify bytes, track fill position
   logic    push, queue_full, pop, head_valid;
   cmd_type push_cmd, head_cmd;
   rsp_type out_rsp;

   ler_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .line_limit (limit_ff),
      .descriptor (desc_ff),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   // short command queue decouples the two halves
   ler_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // back: expand each command into its results
   ler_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rsp    (out_rsp)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {(RSP_DATA_W - BYTE_W - INDEX_W - POS_W)'(0),
                       out_rsp.length, out_rsp.index, out_rsp.data};
   assign rsp_tuser = out_rsp.kind;
   assign rsp_tlast = out_rsp.last;

endmodule

`default_nettype wire

[rtl/ler_front.sv]
`default_nettype none

module ler_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [ler_pkg::BYTE_W-1:0]   in_byte,
   input  wire logic [ler_pkg::POS_W-1:0]    line_limit,
   input  wire logic [ler_pkg::BYTE_W-1:0]   descriptor,
   output logic                              push,
   output ler_pkg::cmd_type                  push_cmd,
   input  wire logic                         queue_full
);
   import ler_pkg::*;

   logic [POS_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0] eff_limit;
   logic [POS_W-1:0] pos_next;
   logic             accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;
   assign pos_next = fill_ff + POS_W'(1);

   always_comb begin
      if (line_limit == '0) begin
         eff_limit = POS_W'(1);
      end else if (line_limit > POS_W'(MAX_LINE)) begin
         eff_limit = POS_W'(MAX_LINE);
      end else begin
         eff_limit = line_limit;
      end
   end

   // classify the byte and work out the new fill position
   always_comb begin
      push_cmd.op     = OP_ERROR;
      push_cmd.data   = in_byte;
      push_cmd.index  = fill_ff[INDEX_W-1:0];
      push_cmd.length = pos_next;
      fill_in         = fill_ff;
      push            = accept;
      priority if (descriptor != '0) begin
         push_cmd.op = OP_ERROR;
      end else if (in_byte == CH_EOT) begin
         push_cmd.op = OP_EOT;
         if (accept) fill_in = '0;
      end else if (in_byte == CH_BS) begin
         push_cmd.op    = OP_BS;
         push_cmd.index = INDEX_W'(fill_ff - POS_W'(1));
         if (fill_ff == '0) begin
            push = 1'b0;
         end else if (accept) begin
            fill_in = fill_ff - POS_W'(1);
         end
      end else if (in_byte == CH_CR) begin
         push_cmd.op = OP_CR;
         if (accept) fill_in = '0;
      end else if (pos_next >= eff_limit) begin
         push_cmd.op = OP_CHAR_END;
         if (accept) fill_in = '0;
      end else begin
         push_cmd.op = OP_CHAR_MORE;
         if (accept) fill_in = pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ler_queue.sv]
`default_nettype none

module ler_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ler_pkg::cmd_type  push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output ler_pkg::cmd_type       head_cmd
);
   import ler_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QUEUE_CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ler_back.sv]
`default_nettype none

module ler_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire ler_pkg::cmd_type head_cmd,
   output logic                  pop,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output ler_pkg::rsp_type      out_rsp
);
   import ler_pkg::*;

   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   rsp_type    cur;
   logic       load;

   // one result of the head command at the current step
   always_comb begin
      cur.kind   = KIND_ECHO;
      cur.data   = '0;
      cur.index  = '0;
      cur.length = '0;
      cur.last   = 1'b0;
      unique case (head_cmd.op)
         OP_ERROR: begin
            cur.kind = KIND_ERROR;
            cur.last = 1'b1;
         end
         OP_EOT: begin
            cur.kind = KIND_DONE;
            cur.last = 1'b1;
         end
         OP_BS: begin
            unique case (step_ff)
               2'd0: begin
                  cur.kind  = KIND_WRITE;
                  cur.data  = CH_SPACE;
                  cur.index = head_cmd.index;
               end
               2'd1: cur.data = CH_BS;
               2'd2: cur.data = CH_SPACE;
               default: begin
                  cur.data = CH_BS;
                  cur.last = 1'b1;
               end
            endcase
         end
         OP_CR: begin
            unique case (step_ff)
               2'd0: begin
                  cur.kind  = KIND_WRITE;
                  cur.data  = CH_LF;
                  cur.index = head_cmd.index;
               end
               2'd1: cur.data = CH_CR;
               2'd2: cur.data = CH_LF;
               default: begin
                  cur.kind   = KIND_DONE;
                  cur.length = head_cmd.length;
                  cur.last   = 1'b1;
               end
            endcase
         end
         OP_CHAR_MORE: begin
            if (step_ff == 2'd0) begin
               cur.kind  = KIND_WRITE;
               cur.data  = head_cmd.data;
               cur.index = head_cmd.index;
            end else begin
               cur.data = head_cmd.data;
               cur.last = 1'b1;
            end
         end
         OP_CHAR_END: begin
            unique case (step_ff)
               2'd0: begin
                  cur.kind  = KIND_WRITE;
                  cur.data  = head_cmd.data;
                  cur.index = head_cmd.index;
               end
               2'd1: cur.data = head_cmd.data;
               default: begin
                  cur.kind   = KIND_DONE;
                  cur.length = head_cmd.length;
                  cur.last   = 1'b1;
               end
            endcase
         end
         default: begin
            cur.kind = KIND_ERROR;
            cur.last = 1'b1;
         end
      endcase
   end

   assign load = !valid_ff || out_ready;
   assign pop  = load && head_valid && cur.last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            rsp_in  = cur;
            step_in = cur.last ? 2'd0 : step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

[verif/tb_line_edit_receiver.sv]
module tb_line_edit_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   import ler_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 200;     // long result-side hold-off, fills the queue
   localparam int QUIET_CYCLES = 16;      // quiet stretch to catch stray results
   localparam int LONG_LINE    = 64;      // bytes offered while the result side holds off
   localparam int RAND_PHASES  = 9;
   localparam int PHASE_ITEMS  = 8;

   // what one row of the directed table does
   typedef enum logic [1:0] {
      ROW_CSR,        // register write while idle
      ROW_RX,         // byte, results from the predictor
      ROW_RX_TYPED    // byte, result typed into the row
   } row_kind_type;

   typedef struct packed {
      row_kind_type           act;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  value;     // register value or byte in the low bits
      logic                   typed_n;   // 1 if the row gives one typed result, else none
      rsp_type                typed;
   } stim_row_type;

   localparam rsp_type NO_RSP   = rsp_type'('0);
   localparam rsp_type EOT_DONE = '{kind: KIND_DONE, data: '0, index: '0, length: '0,
                                    last: 1'b1};
   localparam rsp_type BAD_DESC = '{kind: KIND_ERROR, data: '0, index: '0, length: '0,
                                    last: 1'b1};

   // directed part: extremes, every character class, every special case
   localparam int N_ROWS = 26;
   stim_row_type directed_rows [N_ROWS] = '{
      // backspace right after reset is at line start: dropped, nothing comes out
      '{ROW_RX_TYPED, CSR_LINE_LIMIT, {1'b0, CH_BS},  1'b0, NO_RSP},
      // end-of-transmission on an empty line
      '{ROW_RX_TYPED, CSR_LINE_LIMIT, {1'b0, CH_EOT}, 1'b1, EOT_DONE},
      '{ROW_RX,       CSR_LINE_LIMIT, 9'h041,         1'b0, NO_RSP},
      '{ROW_RX,       CSR_LINE_LIMIT, 9'h0ff,         1'b0, NO_RSP},
      '{ROW_RX,       CSR_LINE_LIMIT, 9'h000,         1'b0, NO_RSP},
      // backspace inside a line: blank and echo bs, space, bs
      '{ROW_RX,       CSR_LINE_LIMIT, {1'b0, CH_BS},  1'b0, NO_RSP},
      '{ROW_RX,       CSR_LINE_LIMIT, {1'b0, CH_CR},  1'b0, NO_RSP},
      // limit zero behaves as one: every byte ends a line
      '{ROW_CSR,      CSR_LINE_LIMIT, 9'd0,           1'b0, NO_RSP},
      '{ROW_RX,       CSR_LINE_LIMIT, 9'h07e,         1'b0, NO_RSP},
      '{ROW_CSR,      CSR_LINE_LIMIT, 9'd2,           1'b0, NO_RSP},
      '{ROW_RX,       CSR_LINE_LIMIT, 9'h061,         1'b0, NO_RSP},
      '{ROW_RX,       CSR_LINE_LIMIT, 9'h062,         1'b0, NO_RSP},
      '{ROW_RX,       CSR_LINE_LIMIT, 9'h063,         1'b0, NO_RSP},
      // limit lowered to the fill position: next byte stored, then line ends
      '{ROW_CSR,      CSR_LINE_LIMIT, 9'd1,           1'b0, NO_RSP},
      '{ROW_RX,       CSR_LINE_LIMIT, 9'h064,         1'b0, NO_RSP},
      // limit above the buffer size saturates
      '{ROW_CSR,      CSR_LINE_LIMIT, 9'd511,         1'b0, NO_RSP},
      '{ROW_RX,       CSR_LINE_LIMIT, 9'h080,         1'b0, NO_RSP},
      // end-of-transmission drops a partly built line
      '{ROW_RX_TYPED, CSR_LINE_LIMIT, {1'b0, CH_EOT}, 1'b1, EOT_DONE},
      // bad descriptor: every byte class gives one error item
      '{ROW_CSR,      CSR_DESCRIPTOR, 9'h0ff,         1'b0, NO_RSP},
      '{ROW_RX_TYPED, CSR_LINE_LIMIT, 9'h041,         1'b1, BAD_DESC},
      '{ROW_RX_TYPED, CSR_LINE_LIMIT, {1'b0, CH_EOT}, 1'b1, BAD_DESC},
      '{ROW_RX_TYPED, CSR_LINE_LIMIT, {1'b0, CH_BS},  1'b1, BAD_DESC},
      '{ROW_CSR,      CSR_DESCRIPTOR, 9'h001,         1'b0, NO_RSP},
      '{ROW_RX_TYPED, CSR_LINE_LIMIT, {1'b0, CH_CR},  1'b1, BAD_DESC},
      '{ROW_CSR,      CSR_DESCRIPTOR, 9'h000,         1'b0, NO_RSP},
      // carriage return on an empty line: line of length one
      '{ROW_RX,       CSR_LINE_LIMIT, {1'b0, CH_CR},  1'b0, NO_RSP}
   };

   // dut ports, inputs known from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;   // rx_byte[7:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // data_byte[7:0], write_index[15:8],
                                              // line_length[24:16], zeros
   logic [KIND_W-1:0]      rsp_tuser;         // kind[1:0]
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // predictor copy of the block's registers and line state
   logic [POS_W-1:0]       line_fill   = '0;
   logic [POS_W-1:0]       limit_shadow = POS_W'(MAX_LINE);
   logic [BYTE_W-1:0]      desc_shadow = '0;

   rsp_type                awaited_results [$];
   int unsigned            mismatch_count = 0;
   int unsigned            cycle_count    = 0;
   int unsigned            sender_pct     = 0;   // chance in percent the sender idles
   int unsigned            receiver_pct   = 0;   // chance in percent the receiver stalls
   bit                     hold_off_pending = 1'b0;

   line_edit_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic rsp_type make_rsp(kind_type kind, logic [BYTE_W-1:0] data,
                                        logic [INDEX_W-1:0] index,
                                        logic [POS_W-1:0] length, logic last);
      rsp_type r;
      r.kind   = kind;
      r.data   = data;
      r.index  = index;
      r.length = length;
      r.last   = last;
      return r;
   endfunction

   // line editing of one received byte: results it causes, state updated
   function automatic void predict_rx_byte(input logic [BYTE_W-1:0] c, ref rsp_type res[$]);
      logic [POS_W-1:0] lim;
      logic [POS_W-1:0] pos;
      res.delete();
      lim = limit_shadow;
      if (lim == 0) lim = POS_W'(1);
      if (lim > MAX_LINE) lim = POS_W'(MAX_LINE);
      pos = line_fill;
      if (desc_shadow != 0) begin
         res.push_back(make_rsp(KIND_ERROR, '0, '0, '0, 1'b1));
      end else if (c == CH_EOT) begin
         line_fill = '0;
         res.push_back(make_rsp(KIND_DONE, '0, '0, '0, 1'b1));
      end else if (c == CH_BS) begin
         if (pos != 0) begin
            pos = pos - POS_W'(1);
            line_fill = pos;
            res.push_back(make_rsp(KIND_WRITE, CH_SPACE, pos[INDEX_W-1:0], '0, 1'b0));
            res.push_back(make_rsp(KIND_ECHO, CH_BS, '0, '0, 1'b0));
            res.push_back(make_rsp(KIND_ECHO, CH_SPACE, '0, '0, 1'b0));
            res.push_back(make_rsp(KIND_ECHO, CH_BS, '0, '0, 1'b1));
         end
      end else if (c == CH_CR) begin
         res.push_back(make_rsp(KIND_WRITE, CH_LF, pos[INDEX_W-1:0], '0, 1'b0));
         res.push_back(make_rsp(KIND_ECHO, CH_CR, '0, '0, 1'b0));
         res.push_back(make_rsp(KIND_ECHO, CH_LF, '0, '0, 1'b0));
         res.push_back(make_rsp(KIND_DONE, '0, '0, pos + 9'd1, 1'b1));
         line_fill = '0;
      end else begin
         res.push_back(make_rsp(KIND_WRITE, c, pos[INDEX_W-1:0], '0, 1'b0));
         pos = pos + POS_W'(1);
         if (pos >= lim) begin
            res.push_back(make_rsp(KIND_ECHO, c, '0, '0, 1'b0));
            res.push_back(make_rsp(KIND_DONE, '0, '0, pos, 1'b1));
            line_fill = '0;
         end else begin
            res.push_back(make_rsp(KIND_ECHO, c, '0, '0, 1'b1));
            line_fill = pos;
         end
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // one result item against the oldest awaited one
   function automatic void check_result();
      rsp_type want;
      if (awaited_results.size() == 0) begin
         $error("unexpected result item: tuser %0d tdata %h tlast %0b",
                rsp_tuser, rsp_tdata, rsp_tlast);
         mismatch_count++;
      end else begin
         want = awaited_results.pop_front();
         check_field("kind",        want.kind,   rsp_tuser);
         check_field("data_byte",   want.data,   rsp_tdata[7:0]);
         check_field("write_index", want.index,  rsp_tdata[15:8]);
         check_field("line_length", want.length, rsp_tdata[24:16]);
         check_field("last",        want.last,   rsp_tlast);
         check_field("tdata_pad",   0,           rsp_tdata[RSP_DATA_W-1:25]);
      end
   endfunction

   function automatic logic [BYTE_W-1:0] ordinary_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255));
      while (b == CH_EOT || b == CH_BS || b == CH_CR);
      return b;
   endfunction

   // mostly line text, some editing and line ends, a little raw noise
   function automatic logic [BYTE_W-1:0] random_rx_byte();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return ordinary_byte();
      else if (pick < 82) return CH_BS;
      else if (pick < 90) return CH_CR;
      else if (pick < 94) return CH_EOT;
      else return BYTE_W'($urandom_range(0, 255));
   endfunction

   // offer one byte, return at the edge it is taken; tvalid stays high
   task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(0, 99) < sender_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic take_rx_byte(input logic [BYTE_W-1:0] b);
      rsp_type fresh [$];
      send_rx_byte(b);
      predict_rx_byte(b, fresh);
      foreach (fresh[k]) awaited_results.push_back(fresh[k]);
   endtask

   // stop offering, let every awaited item drain, then a quiet stretch
   task automatic settle();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_LINE_LIMIT) limit_shadow = value;
      else desc_shadow = value[BYTE_W-1:0];
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            sender_pct   = 12;
            receiver_pct = 54;
         end
         1: begin
            sender_pct   = 54;
            receiver_pct = 12;
         end
         default: begin
            sender_pct   = 0;
            receiver_pct = 0;
         end
      endcase
   endtask

   // result side: check each accepted item, stall at random, one long hold-off
   initial begin : rsp_side
      int held;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result();
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= receiver_pct);
      end
   end

   // stimulus
   initial begin : req_side
      rsp_type scratch [$];
      logic [CSR_DATA_W-1:0] lim;
      logic [BYTE_W-1:0] b;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      set_idling(0);
      foreach (directed_rows[i]) begin
         case (directed_rows[i].act)
            ROW_CSR: begin
               write_csr(directed_rows[i].idx, directed_rows[i].value);
            end
            ROW_RX: begin
               take_rx_byte(directed_rows[i].value[BYTE_W-1:0]);
            end
            default: begin
               // typed rows still step the predictor to keep its line state
               b = directed_rows[i].value[BYTE_W-1:0];
               send_rx_byte(b);
               predict_rx_byte(b, scratch);
               if (directed_rows[i].typed_n) awaited_results.push_back(directed_rows[i].typed);
            end
         endcase
      end

      // random phases, each with its own register setting
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         settle();
         set_idling(ph / 3);
         case ($urandom_range(0, 5))
            0: lim = 9'd0;
            1: lim = 9'd1;
            2: lim = 9'd511;
            3: lim = 9'd256;
            4: lim = CSR_DATA_W'($urandom_range(2, 8));
            default: lim = CSR_DATA_W'($urandom_range(9, 40));
         endcase
         if (ph == 0) lim = 9'd256;
         write_csr(CSR_LINE_LIMIT, lim);
         write_csr(CSR_DESCRIPTOR, (ph == 5) ? CSR_DATA_W'($urandom_range(1, 255)) : '0);
         if (ph == 0) begin
            // a run of line text while the result side holds off
            hold_off_pending = 1'b1;
            repeat (LONG_LINE) take_rx_byte(ordinary_byte());
         end else begin
            repeat (PHASE_ITEMS) take_rx_byte(random_rx_byte());
         end
      end

      // drain and a quiet tail to catch stray results
      settle();

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
